>>> rtl/ac034_pkg.sv
// ----------------------------------------------------------------------------
// ASTERIX category 034 record parser package
// Phase codes, result kinds, error codes and the result record type.
// ----------------------------------------------------------------------------
package ac034_pkg;

	localparam int unsigned MAX_BLOCK_BYTES_DEF = 65535;
	localparam int unsigned RES_SLOTS = 3;
	localparam logic [7:0] CAT_CODE = 8'd34;

	localparam logic [3:0] PH_CAT       = 4'd0;
	localparam logic [3:0] PH_LEN_HI    = 4'd1;
	localparam logic [3:0] PH_LEN_LO    = 4'd2;
	localparam logic [3:0] PH_FSPEC     = 4'd3;
	localparam logic [3:0] PH_FIXED     = 4'd4;
	localparam logic [3:0] PH_SUBHDR    = 4'd5;
	localparam logic [3:0] PH_SUBDATA   = 4'd6;
	localparam logic [3:0] PH_COUNT_REP = 4'd7;
	localparam logic [3:0] PH_COUNT_VAL = 4'd8;
	localparam logic [3:0] PH_SKIPLEN   = 4'd9;
	localparam logic [3:0] PH_SKIP      = 4'd10;
	localparam logic [3:0] PH_SP_LEN    = 4'd11;
	localparam logic [3:0] PH_SP_SUB    = 4'd12;
	localparam logic [3:0] PH_SP_TLEN   = 4'd13;
	localparam logic [3:0] PH_SP_TEXT   = 4'd14;
	localparam logic [3:0] PH_DONE      = 4'd15;

	localparam logic [4:0] K_SOURCE   = 5'd0;
	localparam logic [4:0] K_TYPE     = 5'd1;
	localparam logic [4:0] K_TIME     = 5'd2;
	localparam logic [4:0] K_SECTOR   = 5'd3;
	localparam logic [4:0] K_SPEED    = 5'd4;
	localparam logic [4:0] K_STATUS   = 5'd5;
	localparam logic [4:0] K_MODE     = 5'd9;
	localparam logic [4:0] K_CNT_REPS = 5'd13;
	localparam logic [4:0] K_COUNT    = 5'd14;
	localparam logic [4:0] K_FILTER   = 5'd15;
	localparam logic [4:0] K_HEIGHT   = 5'd16;
	localparam logic [4:0] K_LAT      = 5'd17;
	localparam logic [4:0] K_LON      = 5'd18;
	localparam logic [4:0] K_COL_RNG  = 5'd19;
	localparam logic [4:0] K_COL_AZ   = 5'd20;
	localparam logic [4:0] K_TEXT     = 5'd21;
	localparam logic [4:0] K_REC_END  = 5'd22;
	localparam logic [4:0] K_ERROR    = 5'd23;

	localparam logic [2:0] E_CATEGORY = 3'd1;
	localparam logic [2:0] E_SHORT    = 3'd2;
	localparam logic [2:0] E_FSPEC    = 3'd3;
	localparam logic [2:0] E_SUB_OVR  = 3'd4;
	localparam logic [2:0] E_SUB_EXT  = 3'd5;
	localparam logic [2:0] E_FSPEC3   = 3'd6;
	localparam logic [2:0] E_RECORD   = 3'd7;

	typedef struct packed {
		logic        [2:0]  error_code;
		logic        [7:0]  sub_index;
		logic signed [27:0] value;
		logic        [4:0]  item_kind;
	} res_t;

	typedef res_t [RES_SLOTS-1:0] res_arr_t;

	function automatic res_t mk(input logic [4:0] k, input logic [27:0] v,
		input logic [7:0] s, input logic [2:0] e);
		res_t r;
		r.item_kind = k;
		r.value = signed'(v);
		r.sub_index = s;
		r.error_code = e;
		return r;
	endfunction

endpackage

>>> rtl/ac034_parse_core.sv
// ----------------------------------------------------------------------------
// ASTERIX category 034 parse core
// Holds the parser state and decodes one byte per transaction into up to
// three result records.
// ----------------------------------------------------------------------------
module ac034_parse_core #(
	parameter int unsigned MAX_BLOCK_BYTES = ac034_pkg::MAX_BLOCK_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                acc,
	input  logic [7:0]          b,
	input  logic                blast,
	output ac034_pkg::res_arr_t res,
	output logic [1:0]          res_cnt
);

	logic [3:0]  phase_q, n_phase;
	logic [15:0] len_q, n_len;
	logic [15:0] pos_q, n_pos;
	logic [7:0]  fs0_q, n_fs0, fs1_q, n_fs1;
	logic [23:0] shift_q, n_shift;
	logic [7:0]  bl_q, n_bl;
	logic [7:0]  flags_q, n_flags;
	logic [7:0]  rep_q, n_rep;
	logic        failed_q, n_failed;
	logic [1:0]  fcnt_q, n_fcnt;
	logic [3:0]  cur_q, n_cur;
	logic [4:0]  skind_q, n_skind;
	logic [7:0]  tidx_q, n_tidx;
	logic        cf_q, n_cf;
	logic        skip_sp_q;

	logic        at_last, do_next, do_pick, found, has2;
	logic [3:0]  nf_start, nf_f;
	logic [7:0]  fl;
	logic [33:0] tod;
	logic signed [18:0] coll, coll_adj;
	logic [4:0]  typ;

	function automatic logic [1:0] sat_inc(input logic [1:0] c);
		return (c == 2'd3) ? c : c + 2'd1;
	endfunction

	function automatic ac034_pkg::res_arr_t put(input ac034_pkg::res_arr_t a,
		input logic [1:0] c, input ac034_pkg::res_t r);
		ac034_pkg::res_arr_t o;
		o = a;
		if (c != 2'd3) begin
			o[c] = r;
		end
		return o;
	endfunction

	assign at_last = ({1'b0, pos_q} + 17'd1) == {1'b0, len_q};
	assign tod = {10'd0, shift_q[15:0], b} * 34'd1000 + 34'd64;
	assign coll = 19'(signed'(b)) * 19'sd1852;
	assign coll_adj = (coll + (coll[18] ? 19'sd127 : 19'sd0)) >>> 7;

	always_comb begin
		n_phase = phase_q; n_len = len_q; n_pos = pos_q; n_fs0 = fs0_q; n_fs1 = fs1_q;
		n_shift = shift_q; n_bl = bl_q; n_flags = flags_q; n_rep = rep_q;
		n_failed = failed_q; n_fcnt = fcnt_q; n_cur = cur_q; n_skind = skind_q;
		n_tidx = tidx_q; n_cf = cf_q;
		res = '0; res_cnt = 2'd0;
		do_next = 1'b0; do_pick = 1'b0; nf_start = 4'd0; nf_f = 4'd0; found = 1'b0;
		has2 = 1'b0; fl = 8'd0; typ = 5'd0;
		if (acc) begin
			if (failed_q || phase_q == ac034_pkg::PH_DONE) begin
				if (blast) begin
					n_phase = ac034_pkg::PH_CAT; n_pos = 16'd0; n_failed = 1'b0; n_fcnt = 2'd0;
				end
			end else begin
				case (phase_q)
					ac034_pkg::PH_CAT: begin
						if (b != ac034_pkg::CAT_CODE) begin
							res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_ERROR, 28'd0, 8'd0,
								ac034_pkg::E_CATEGORY));
							res_cnt = sat_inc(res_cnt); n_failed = 1'b1;
						end else if (blast) begin
							res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_ERROR, 28'd0, 8'd0,
								ac034_pkg::E_SHORT));
							res_cnt = sat_inc(res_cnt); n_failed = 1'b1;
						end else begin
							n_phase = ac034_pkg::PH_LEN_HI;
						end
					end
					ac034_pkg::PH_LEN_HI: begin
						n_len = {b, 8'd0};
						if (blast) begin
							res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_ERROR, 28'd0, 8'd0,
								ac034_pkg::E_SHORT));
							res_cnt = sat_inc(res_cnt); n_failed = 1'b1;
						end else begin
							n_phase = ac034_pkg::PH_LEN_LO;
						end
					end
					ac034_pkg::PH_LEN_LO: begin
						n_len = {len_q[15:8], b};
						if (n_len < 16'd3 || {16'd0, n_len} > 32'(MAX_BLOCK_BYTES)) begin
							res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_ERROR, 28'd0, 8'd0,
								ac034_pkg::E_RECORD));
							res_cnt = sat_inc(res_cnt); n_failed = 1'b1;
						end else if (n_len == 16'd3) begin
							n_phase = ac034_pkg::PH_DONE;
						end else if (blast) begin
							res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_ERROR, 28'd0, 8'd0,
								ac034_pkg::E_SHORT));
							res_cnt = sat_inc(res_cnt); n_failed = 1'b1;
						end else begin
							n_phase = ac034_pkg::PH_FSPEC; n_fcnt = 2'd0;
						end
					end
					default: begin
						if (blast && ({1'b0, pos_q} + 17'd1) < {1'b0, len_q}) begin
							res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_ERROR, 28'd0, 8'd0,
								ac034_pkg::E_SHORT));
							res_cnt = sat_inc(res_cnt); n_failed = 1'b1;
						end else begin
							case (phase_q)
								ac034_pkg::PH_FSPEC: begin
									if (n_fcnt == 2'd0) begin
										n_fs1 = 8'd0; n_fs0 = b;
									end else if (n_fcnt == 2'd1) begin
										n_fs1 = b;
									end
									n_fcnt = sat_inc(n_fcnt);
									if (b[0]) begin
										if (at_last) begin
											res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_ERROR,
												28'd0, 8'd0, ac034_pkg::E_FSPEC));
											res_cnt = sat_inc(res_cnt); n_failed = 1'b1;
										end
									end else begin
										do_next = 1'b1; nf_start = 4'd0;
									end
								end
								ac034_pkg::PH_FIXED: begin
									n_shift = {n_shift[15:0], b};
									n_bl = n_bl - 8'd1;
									if (cur_q == 4'd10) begin
										if (n_bl == 8'd6) begin
											res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_HEIGHT,
												28'(signed'(n_shift[15:0])), 8'd0, 3'd0));
											res_cnt = sat_inc(res_cnt);
										end else if (n_bl == 8'd3) begin
											res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_LAT,
												28'(signed'(n_shift)), 8'd0, 3'd0));
											res_cnt = sat_inc(res_cnt);
										end else if (n_bl == 8'd0) begin
											res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_LON,
												28'(signed'(n_shift)), 8'd0, 3'd0));
											res_cnt = sat_inc(res_cnt);
										end
									end else if (cur_q == 4'd11) begin
										if (n_bl == 8'd1) begin
											res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_COL_RNG,
												28'(coll_adj), 8'd0, 3'd0));
											res_cnt = sat_inc(res_cnt);
										end else if (n_bl == 8'd0) begin
											res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_COL_AZ,
												28'(signed'(b)), 8'd0, 3'd0));
											res_cnt = sat_inc(res_cnt);
										end
									end
									if (n_bl == 8'd0) begin
										case (cur_q)
											4'd0: begin
												res = put(res, res_cnt, ac034_pkg::mk(
													ac034_pkg::K_SOURCE, {12'd0, n_shift[15:0]}, 8'd0, 3'd0));
												res_cnt = sat_inc(res_cnt);
											end
											4'd1: begin
												res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_TYPE,
													(b >= 8'd1 && b <= 8'd4) ? {20'd0, b} : 28'd0,
													8'd0, 3'd0));
												res_cnt = sat_inc(res_cnt);
											end
											4'd2: begin
												res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_TIME,
													{1'b0, tod[33:7]}, 8'd0, 3'd0));
												res_cnt = sat_inc(res_cnt);
											end
											4'd3: begin
												res = put(res, res_cnt, ac034_pkg::mk(
													ac034_pkg::K_SECTOR, {20'd0, b}, 8'd0, 3'd0));
												res_cnt = sat_inc(res_cnt);
											end
											4'd4: begin
												res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_SPEED,
													{12'd0, n_shift[15:0]}, 8'd0, 3'd0));
												res_cnt = sat_inc(res_cnt);
											end
											4'd9: begin
												res = put(res, res_cnt, ac034_pkg::mk(
													ac034_pkg::K_FILTER, {20'd0, b}, 8'd0, 3'd0));
												res_cnt = sat_inc(res_cnt);
											end
											default: begin
											end
										endcase
										do_next = 1'b1; nf_start = cur_q + 4'd1;
									end
								end
								ac034_pkg::PH_SUBHDR: begin
									if (n_cf) begin
										n_flags = b; n_cf = 1'b0;
									end
									if (b[0]) begin
										if (at_last) begin
											res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_ERROR,
												28'd0, 8'd0, ac034_pkg::E_SUB_OVR));
											res_cnt = sat_inc(res_cnt); n_failed = 1'b1;
										end
									end else if (n_flags[0]) begin
										res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_ERROR,
											28'd0, 8'd0, ac034_pkg::E_SUB_EXT));
										res_cnt = sat_inc(res_cnt); n_failed = 1'b1;
									end else begin
										do_pick = 1'b1;
									end
								end
								ac034_pkg::PH_SUBDATA: begin
									n_shift = {n_shift[15:0], b};
									n_bl = n_bl - 8'd1;
									if (n_bl == 8'd0) begin
										res = put(res, res_cnt, ac034_pkg::mk(skind_q,
											{12'd0, n_shift[15:0]}, 8'd0, 3'd0));
										res_cnt = sat_inc(res_cnt);
										do_pick = 1'b1;
									end
								end
								ac034_pkg::PH_COUNT_REP: begin
									res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_CNT_REPS,
										{20'd0, b}, 8'd0, 3'd0));
									res_cnt = sat_inc(res_cnt);
									n_rep = b;
									if (b == 8'd0) begin
										do_next = 1'b1; nf_start = 4'd8;
									end else begin
										n_phase = ac034_pkg::PH_COUNT_VAL; n_bl = 8'd2; n_shift = '0;
									end
								end
								ac034_pkg::PH_COUNT_VAL: begin
									n_shift = {n_shift[15:0], b};
									n_bl = n_bl - 8'd1;
									if (n_bl == 8'd0) begin
										typ = n_shift[15:11];
										if (typ <= 5'd16) begin
											res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_COUNT,
												{17'd0, n_shift[10:0]}, {3'd0, typ}, 3'd0));
											res_cnt = sat_inc(res_cnt);
										end
										n_rep = n_rep - 8'd1;
										if (n_rep == 8'd0) begin
											do_next = 1'b1; nf_start = 4'd8;
										end else begin
											n_bl = 8'd2; n_shift = '0;
										end
									end
								end
								ac034_pkg::PH_SKIPLEN, ac034_pkg::PH_SP_LEN: begin
									if (b >= 8'd2) begin
										n_bl = b - 8'd1; n_cf = 1'b1;
										n_phase = (phase_q == ac034_pkg::PH_SKIPLEN) ?
											ac034_pkg::PH_SKIP : ac034_pkg::PH_SP_SUB;
									end else begin
										do_next = 1'b1; nf_start = cur_q + 4'd1;
									end
								end
								ac034_pkg::PH_SKIP: begin
									n_bl = n_bl - 8'd1;
									if (n_bl == 8'd0) begin
										do_next = 1'b1; nf_start = cur_q + 4'd1;
									end
								end
								ac034_pkg::PH_SP_SUB, ac034_pkg::PH_SP_TLEN,
								ac034_pkg::PH_SP_TEXT: begin
									n_bl = n_bl - 8'd1;
									if (phase_q == ac034_pkg::PH_SP_SUB) begin
										if (n_cf) begin
											n_flags = b; n_cf = 1'b0;
										end
										if (!b[0]) begin
											n_phase = n_flags[7] ? ac034_pkg::PH_SP_TLEN :
												ac034_pkg::PH_SKIP;
										end
									end else if (phase_q == ac034_pkg::PH_SP_TLEN) begin
										n_rep = b; n_tidx = 8'd0;
										n_phase = (b != 8'd0) ? ac034_pkg::PH_SP_TEXT :
											ac034_pkg::PH_SKIP;
									end else begin
										res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_TEXT,
											{20'd0, b}, tidx_q, 3'd0));
										res_cnt = sat_inc(res_cnt);
										n_tidx = n_tidx + 8'd1;
										n_rep = n_rep - 8'd1;
										if (n_rep == 8'd0) begin
											n_phase = ac034_pkg::PH_SKIP;
										end
									end
									if (n_bl == 8'd0) begin
										do_next = 1'b1; nf_start = cur_q + 4'd1;
									end
								end
								default: begin
								end
							endcase

							if (do_pick) begin
								fl = n_flags & 8'h9C;
								if (fl == 8'd0) begin
									do_next = 1'b1; nf_start = cur_q + 4'd1;
								end else begin
									n_phase = ac034_pkg::PH_SUBDATA; n_shift = '0;
									n_bl = 8'd1;
									if (fl[7]) begin
										n_flags[7] = 1'b0;
										n_skind = (cur_q == 4'd5) ? ac034_pkg::K_STATUS :
											ac034_pkg::K_MODE;
									end else if (fl[4]) begin
										n_flags[4] = 1'b0;
										n_skind = ((cur_q == 4'd5) ? ac034_pkg::K_STATUS :
											ac034_pkg::K_MODE) + 5'd1;
									end else if (fl[3]) begin
										n_flags[3] = 1'b0;
										n_skind = ((cur_q == 4'd5) ? ac034_pkg::K_STATUS :
											ac034_pkg::K_MODE) + 5'd2;
									end else begin
										n_flags[2] = 1'b0;
										n_skind = ((cur_q == 4'd5) ? ac034_pkg::K_STATUS :
											ac034_pkg::K_MODE) + 5'd3;
										if (cur_q == 4'd5) begin
											n_bl = 8'd2;
										end
									end
								end
							end

							if (do_next) begin
								has2 = n_fs0[0];
								for (int f = 13; f >= 0; f--) begin
									if (4'(f) >= nf_start) begin
										if ((f < 7) ? n_fs0[7 - f] : (has2 && n_fs1[14 - f])) begin
											found = 1'b1; nf_f = 4'(f);
										end
									end
								end
								if (found) begin
									n_cur = nf_f; n_shift = '0;
									case (nf_f)
										4'd0, 4'd4, 4'd11: begin
											n_phase = ac034_pkg::PH_FIXED; n_bl = 8'd2;
										end
										4'd1, 4'd3, 4'd9: begin
											n_phase = ac034_pkg::PH_FIXED; n_bl = 8'd1;
										end
										4'd2: begin
											n_phase = ac034_pkg::PH_FIXED; n_bl = 8'd3;
										end
										4'd8, 4'd10: begin
											n_phase = ac034_pkg::PH_FIXED; n_bl = 8'd8;
										end
										4'd5, 4'd6: begin
											n_phase = ac034_pkg::PH_SUBHDR; n_cf = 1'b1;
										end
										4'd7: n_phase = ac034_pkg::PH_COUNT_REP;
										4'd12: n_phase = ac034_pkg::PH_SKIPLEN;
										default: n_phase = skip_sp_q ? ac034_pkg::PH_SKIPLEN :
											ac034_pkg::PH_SP_LEN;
									endcase
								end else if (has2 && n_fs1[0]) begin
									res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_ERROR,
										28'd0, 8'd0, ac034_pkg::E_FSPEC3));
									res_cnt = sat_inc(res_cnt); n_failed = 1'b1;
								end else begin
									res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_REC_END,
										28'd0, 8'd0, 3'd0));
									res_cnt = sat_inc(res_cnt);
									n_phase = ac034_pkg::PH_FSPEC; n_fcnt = 2'd0;
								end
							end

							if (!n_failed && at_last) begin
								if (n_phase == ac034_pkg::PH_FSPEC && n_fcnt == 2'd0) begin
									n_phase = ac034_pkg::PH_DONE;
								end else begin
									res = put(res, res_cnt, ac034_pkg::mk(ac034_pkg::K_ERROR,
										28'd0, 8'd0, ac034_pkg::E_RECORD));
									res_cnt = sat_inc(res_cnt); n_failed = 1'b1;
								end
							end
						end
					end
				endcase
				if (pos_q != 16'hFFFF) begin
					n_pos = pos_q + 16'd1;
				end
				if (blast) begin
					n_phase = ac034_pkg::PH_CAT; n_pos = 16'd0; n_failed = 1'b0; n_fcnt = 2'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ac034_pkg::PH_CAT;
			len_q <= '0; pos_q <= '0; fs0_q <= '0; fs1_q <= '0; shift_q <= '0;
			bl_q <= '0; flags_q <= '0; rep_q <= '0; failed_q <= 1'b0; fcnt_q <= '0;
			cur_q <= '0; skind_q <= '0; tidx_q <= '0; cf_q <= 1'b0; skip_sp_q <= 1'b0;
		end else begin
			phase_q <= n_phase;
			len_q <= n_len; pos_q <= n_pos; fs0_q <= n_fs0; fs1_q <= n_fs1;
			shift_q <= n_shift; bl_q <= n_bl; flags_q <= n_flags; rep_q <= n_rep;
			failed_q <= n_failed; fcnt_q <= n_fcnt; cur_q <= n_cur; skind_q <= n_skind;
			tidx_q <= n_tidx; cf_q <= n_cf;
			if (cfg_wr_en) begin
				skip_sp_q <= cfg_wr_data;
			end
		end
	end

endmodule

>>> rtl/asterix_cat034_record_parser_unit.sv
// ----------------------------------------------------------------------------
// ASTERIX category 034 record parser unit
// Decodes a category 034 data block, one byte per transaction, into a stream
// of data items, record ends and error reports.
//
// Channel   Direction  Content
// s_axis    in         tdata: data_byte; tlast: block_last
// m_axis    out        tdata: item_kind, value, sub_index, error_code; tlast: last
// cfg       in         cfg_wr_en / cfg_wr_data: skip_special_field
//
// A byte is decoded in the cycle it is taken; its results appear on m_axis
// from the next cycle, one per cycle while m_axis_tready is high, from a three-entry result buffer.
// A byte with one or no result lets a byte enter every cycle while m_axis_tready is high; a byte with
// more results holds s_axis_tready low until the buffer drains to its last
// entry. Reset clears the parser to the block header and empties the buffer.
// ----------------------------------------------------------------------------
module asterix_cat034_record_parser_unit #(
	parameter int unsigned MAX_BLOCK_BYTES = ac034_pkg::MAX_BLOCK_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [4:0] item_kind, [32:5] value,
	                                   // [40:33] sub_index, [43:41] error_code
	output logic        m_axis_tlast
);

	ac034_pkg::res_arr_t res, buf_q;
	logic [1:0] res_cnt, rem_q;
	logic       acc, pop;

	assign s_axis_tready = (rem_q == 2'd0) || (rem_q == 2'd1 && m_axis_tready);
	assign acc = s_axis_tvalid && s_axis_tready;
	assign pop = m_axis_tvalid && m_axis_tready;

	ac034_parse_core #(
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.acc        (acc),
		.b          (s_axis_tdata),
		.blast      (s_axis_tlast),
		.res        (res),
		.res_cnt    (res_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (acc) begin
			rem_q <= res_cnt;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			buf_q <= res;
		end else if (pop) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
		end
	end

	assign m_axis_tvalid = rem_q != 2'd0;
	assign m_axis_tlast = rem_q == 2'd1;
	assign m_axis_tdata = {4'd0, buf_q[0].error_code, buf_q[0].sub_index,
		buf_q[0].value, buf_q[0].item_kind};

endmodule

>>> sim/asterix_cat034_record_parser_unit_test.sv
// ----------------------------------------------------------------------------
// ASTERIX category 034 record parser unit test
// Streams generated category 034 data blocks into the parser, byte by byte,
// and checks every decoded item against an in-bench decoder. Most blocks are
// well formed with random content; the rest are cut short, mislabeled, carry
// bad lengths, flipped bytes or plain noise. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module asterix_cat034_record_parser_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [7:0] b;
		logic       l;
	} byte_t;

	typedef struct {
		logic [4:0]  kind;
		logic [27:0] value;
		logic [7:0]  sub;
		logic [2:0]  err;
		logic        last;
	} item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;

	asterix_cat034_record_parser_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	byte_t      pending_bytes[$];
	item_t      expected_items[$];
	item_t      step_items[$];
	logic [7:0] blk[$];
	int         errors = 0;
	int         cycles = 0;
	int         bytes_sent = 0;
	int         blocks_sent = 0;
	int         items_seen = 0;
	int         send_gap = 0;
	int         recv_gap = 0;
	int         hold_req = 0;
	int         hold_seen = 0;
	int         hold_left = 0;
	bit         send_idle = 1'b1;
	bit         recv_idle = 1'b1;

	// Decoder state.
	logic        skip_sp;
	logic [3:0]  ph;
	logic [15:0] blen;
	logic [15:0] bpos;
	logic [7:0]  fsp0;
	logic [7:0]  fsp1;
	logic [63:0] shreg;
	logic [7:0]  left;
	logic [7:0]  flags;
	logic [7:0]  rep;
	bit          dec_failed;
	int          fcnt;
	logic [7:0]  cur;
	logic [4:0]  skind;
	logic [7:0]  tidx;
	bit          chain;

	task automatic decoder_reset();
		skip_sp = 1'b0;
		ph = ac034_pkg::PH_CAT;
		blen = '0;
		bpos = '0;
		fsp0 = '0;
		fsp1 = '0;
		shreg = '0;
		left = '0;
		flags = '0;
		rep = '0;
		dec_failed = 1'b0;
		fcnt = 0;
		cur = '0;
		skind = '0;
		tidx = '0;
		chain = 1'b0;
	endtask

	task automatic put_item(logic [4:0] k, logic [27:0] v, logic [7:0] s, logic [2:0] e);
		item_t it;
		if (step_items.size() < ac034_pkg::RES_SLOTS) begin
			it.kind = k;
			it.value = v;
			it.sub = s;
			it.err = e;
			it.last = 1'b0;
			step_items.insert(step_items.size(), it);
		end
	endtask

	task automatic put_error(logic [2:0] e);
		put_item(ac034_pkg::K_ERROR, '0, '0, e);
		dec_failed = 1'b1;
	endtask

	function automatic logic [27:0] sx(logic [63:0] v, int bits);
		case (bits)
			8: return {{20{v[7]}}, v[7:0]};
			16: return {{12{v[15]}}, v[15:0]};
			default: return {{4{v[23]}}, v[23:0]};
		endcase
	endfunction

	function automatic bit at_end();
		return {16'd0, bpos} + 32'd1 == {16'd0, blen};
	endfunction

	task automatic set_fixed(logic [7:0] n);
		ph = ac034_pkg::PH_FIXED;
		left = n;
	endtask

	task automatic begin_field(logic [7:0] f);
		cur = f;
		shreg = '0;
		case (f)
			0, 4, 11: set_fixed(8'd2);
			1, 3, 9: set_fixed(8'd1);
			2: set_fixed(8'd3);
			5, 6: begin
				ph = ac034_pkg::PH_SUBHDR;
				chain = 1'b1;
			end
			7: ph = ac034_pkg::PH_COUNT_REP;
			8, 10: set_fixed(8'd8);
			12: ph = ac034_pkg::PH_SKIPLEN;
			default: ph = skip_sp ? ac034_pkg::PH_SKIPLEN : ac034_pkg::PH_SP_LEN;
		endcase
	endtask

	task automatic next_field(logic [7:0] start);
		bit         has2;
		logic [7:0] oct;
		has2 = fsp0[0];
		for (int f = start; f < 14; f++) begin
			oct = f < 7 ? fsp0 : (has2 ? fsp1 : 8'd0);
			if (oct & (8'h80 >> (f % 7))) begin
				begin_field(f[7:0]);
				return;
			end
		end
		if (has2 && fsp1[0]) begin
			put_error(ac034_pkg::E_FSPEC3);
		end else begin
			put_item(ac034_pkg::K_REC_END, '0, '0, '0);
			ph = ac034_pkg::PH_FSPEC;
			fcnt = 0;
		end
	endtask

	task automatic pick_subfield();
		logic [7:0] fl;
		logic [7:0] bit_sel;
		int         idx;
		fl = flags & 8'h9C;
		if (fl == 0) begin
			next_field(cur + 8'd1);
			return;
		end
		if (fl[7]) begin
			bit_sel = 8'h80;
			idx = 0;
		end else if (fl[4]) begin
			bit_sel = 8'h10;
			idx = 1;
		end else if (fl[3]) begin
			bit_sel = 8'h08;
			idx = 2;
		end else begin
			bit_sel = 8'h04;
			idx = 3;
		end
		flags = flags & ~bit_sel;
		skind = (cur == 5 ? ac034_pkg::K_STATUS : ac034_pkg::K_MODE) + idx[4:0];
		left = (idx == 3 && cur == 5) ? 8'd2 : 8'd1;
		shreg = '0;
		ph = ac034_pkg::PH_SUBDATA;
	endtask

	task automatic fixed_byte(logic [7:0] b);
		int          r;
		logic [63:0] t;
		shreg = (shreg << 8) | b;
		left--;
		if (cur == 10) begin
			if (left == 6) put_item(ac034_pkg::K_HEIGHT, sx(shreg, 16), '0, '0);
			else if (left == 3) put_item(ac034_pkg::K_LAT, sx(shreg, 24), '0, '0);
			else if (left == 0) put_item(ac034_pkg::K_LON, sx(shreg, 24), '0, '0);
		end else if (cur == 11) begin
			if (left == 1) begin
				r = $signed(b) * 1852;
				r = r / 128;
				put_item(ac034_pkg::K_COL_RNG, r[27:0], '0, '0);
			end else if (left == 0) begin
				put_item(ac034_pkg::K_COL_AZ, sx({56'd0, b}, 8), '0, '0);
			end
		end
		if (left != 0)
			return;
		case (cur)
			0: put_item(ac034_pkg::K_SOURCE, {12'd0, shreg[15:0]}, '0, '0);
			1: put_item(ac034_pkg::K_TYPE, (b >= 1 && b <= 4) ? {20'd0, b} : 28'd0, '0, '0);
			2: begin
				t = {40'd0, shreg[23:0]} * 64'd1000 + 64'd64;
				t = t >> 7;
				put_item(ac034_pkg::K_TIME, t[27:0], '0, '0);
			end
			3: put_item(ac034_pkg::K_SECTOR, {20'd0, b}, '0, '0);
			4: put_item(ac034_pkg::K_SPEED, {12'd0, shreg[15:0]}, '0, '0);
			9: put_item(ac034_pkg::K_FILTER, {20'd0, b}, '0, '0);
			default: ;
		endcase
		next_field(cur + 8'd1);
	endtask

	task automatic record_byte(logic [7:0] b);
		logic [4:0] typ;
		case (ph)
			ac034_pkg::PH_FSPEC: begin
				if (fcnt == 0) fsp1 = '0;
				if (fcnt == 0) fsp0 = b;
				else if (fcnt == 1) fsp1 = b;
				if (fcnt < 3) fcnt++;
				if (b[0]) begin
					if (at_end()) put_error(ac034_pkg::E_FSPEC);
				end else begin
					next_field(8'd0);
				end
			end
			ac034_pkg::PH_FIXED: fixed_byte(b);
			ac034_pkg::PH_SUBHDR: begin
				if (chain) begin
					flags = b;
					chain = 1'b0;
				end
				if (b[0]) begin
					if (at_end()) put_error(ac034_pkg::E_SUB_OVR);
				end else if (flags[0]) begin
					put_error(ac034_pkg::E_SUB_EXT);
				end else begin
					pick_subfield();
				end
			end
			ac034_pkg::PH_SUBDATA: begin
				shreg = (shreg << 8) | b;
				left--;
				if (left == 0) begin
					put_item(skind, {12'd0, shreg[15:0]}, '0, '0);
					pick_subfield();
				end
			end
			ac034_pkg::PH_COUNT_REP: begin
				put_item(ac034_pkg::K_CNT_REPS, {20'd0, b}, '0, '0);
				rep = b;
				if (b == 0) begin
					next_field(8'd8);
				end else begin
					ph = ac034_pkg::PH_COUNT_VAL;
					left = 8'd2;
					shreg = '0;
				end
			end
			ac034_pkg::PH_COUNT_VAL: begin
				shreg = (shreg << 8) | b;
				left--;
				if (left == 0) begin
					typ = shreg[15:11];
					if (typ <= 16)
						put_item(ac034_pkg::K_COUNT, {17'd0, shreg[10:0]}, {3'd0, typ}, '0);
					rep--;
					if (rep == 0) begin
						next_field(8'd8);
					end else begin
						left = 8'd2;
						shreg = '0;
					end
				end
			end
			ac034_pkg::PH_SKIPLEN, ac034_pkg::PH_SP_LEN: begin
				if (b >= 2) begin
					left = b - 8'd1;
					chain = 1'b1;
					ph = (ph == ac034_pkg::PH_SKIPLEN) ? ac034_pkg::PH_SKIP : ac034_pkg::PH_SP_SUB;
				end else begin
					next_field(cur + 8'd1);
				end
			end
			ac034_pkg::PH_SKIP: begin
				left--;
				if (left == 0) next_field(cur + 8'd1);
			end
			ac034_pkg::PH_SP_SUB, ac034_pkg::PH_SP_TLEN, ac034_pkg::PH_SP_TEXT: begin
				left--;
				if (ph == ac034_pkg::PH_SP_SUB) begin
					if (chain) begin
						flags = b;
						chain = 1'b0;
					end
					if (!b[0]) ph = flags[7] ? ac034_pkg::PH_SP_TLEN : ac034_pkg::PH_SKIP;
				end else if (ph == ac034_pkg::PH_SP_TLEN) begin
					rep = b;
					tidx = '0;
					ph = (b != 0) ? ac034_pkg::PH_SP_TEXT : ac034_pkg::PH_SKIP;
				end else begin
					put_item(ac034_pkg::K_TEXT, {20'd0, b}, tidx, '0);
					tidx++;
					rep--;
					if (rep == 0) ph = ac034_pkg::PH_SKIP;
				end
				if (left == 0) next_field(cur + 8'd1);
			end
			default: ;
		endcase
	endtask

	task automatic restart_block();
		ph = ac034_pkg::PH_CAT;
		bpos = '0;
		dec_failed = 1'b0;
		fcnt = 0;
	endtask

	task automatic decode_byte(logic [7:0] b, logic bl);
		step_items.delete();
		if (dec_failed || ph == ac034_pkg::PH_DONE) begin
			if (bl) restart_block();
			return;
		end
		case (ph)
			ac034_pkg::PH_CAT: begin
				if (b != ac034_pkg::CAT_CODE) put_error(ac034_pkg::E_CATEGORY);
				else if (bl) put_error(ac034_pkg::E_SHORT);
				else ph = ac034_pkg::PH_LEN_HI;
			end
			ac034_pkg::PH_LEN_HI: begin
				blen = {b, 8'd0};
				if (bl) put_error(ac034_pkg::E_SHORT);
				else ph = ac034_pkg::PH_LEN_LO;
			end
			ac034_pkg::PH_LEN_LO: begin
				blen = blen | {8'd0, b};
				if (blen < 3 || blen > ac034_pkg::MAX_BLOCK_BYTES_DEF)
					put_error(ac034_pkg::E_RECORD);
				else if (blen == 3) ph = ac034_pkg::PH_DONE;
				else if (bl) put_error(ac034_pkg::E_SHORT);
				else begin
					ph = ac034_pkg::PH_FSPEC;
					fcnt = 0;
				end
			end
			default: begin
				if (bl && {16'd0, bpos} + 32'd1 < {16'd0, blen}) begin
					put_error(ac034_pkg::E_SHORT);
				end else begin
					record_byte(b);
					if (!dec_failed && at_end()) begin
						if (ph == ac034_pkg::PH_FSPEC && fcnt == 0) ph = ac034_pkg::PH_DONE;
						else put_error(ac034_pkg::E_RECORD);
					end
				end
			end
		endcase
		if (bpos < 16'hffff) bpos++;
		if (bl) restart_block();
		if (step_items.size() > 0) step_items[step_items.size()-1].last = 1'b1;
		foreach (step_items[i]) expected_items.insert(expected_items.size(), step_items[i]);
	endtask

	task automatic report(string what);
		errors++;
		$display("MISMATCH at cycle %0d: %s", cycles, what);
	endtask

	function automatic int gap_len(bit on);
		int r;
		if (!on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				byte_t nb;
				nb = pending_bytes[0];
				pending_bytes.delete(0);
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= nb.b;
				s_axis_tlast <= nb.l;
				send_gap <= gap_len(send_idle);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver, with a single long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= 300;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			recv_gap <= gap_len(recv_idle);
		end
	end

	// Input capture feeds the decoder; output capture checks against it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				decode_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				item_t e;
				items_seen++;
				if (expected_items.size() == 0) begin
					report($sformatf("unexpected item, tdata %h", m_axis_tdata));
				end else begin
					e = expected_items[0];
					expected_items.delete(0);
					if (m_axis_tdata[4:0] !== e.kind)
						report($sformatf("item_kind %0d, want %0d", m_axis_tdata[4:0], e.kind));
					if (m_axis_tdata[32:5] !== e.value)
						report($sformatf("value %h, want %h (kind %0d)",
							m_axis_tdata[32:5], e.value, e.kind));
					if (m_axis_tdata[40:33] !== e.sub)
						report($sformatf("sub_index %0d, want %0d", m_axis_tdata[40:33], e.sub));
					if (m_axis_tdata[43:41] !== e.err)
						report($sformatf("error_code %0d, want %0d", m_axis_tdata[43:41], e.err));
					if (m_axis_tlast !== e.last)
						report($sformatf("tlast %b, want %b", m_axis_tlast, e.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_bytes(logic [7:0] q[$]);
		byte_t nb;
		foreach (q[i]) begin
			nb.b = q[i];
			nb.l = (i == q.size() - 1);
			pending_bytes.insert(pending_bytes.size(), nb);
		end
		bytes_sent += int'(q.size());
		blocks_sent++;
	endtask

	task automatic add_byte(logic [7:0] v);
		blk.insert(blk.size(), v);
	endtask

	task automatic push_rand(int n);
		repeat (n) add_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic build_record(bit allow_err);
		logic [13:0] mask;
		logic [7:0]  o0, o1, prim, sub;
		logic [7:0]  sp[$];
		bit          third;
		int          n, len;
		mask = 14'($urandom_range(0, 16383));
		o0 = '0;
		o1 = '0;
		for (int f = 0; f < 14; f++)
			if (mask[f]) begin
				if (f < 7) o0 |= 8'h80 >> f;
				else o1 |= 8'h80 >> (f - 7);
			end
		third = allow_err && ($urandom_range(0, 19) == 0);
		if (third) o1[0] = 1'b1;
		o0[0] = (o1 != 0);
		add_byte(o0);
		if (o0[0]) add_byte(o1);
		if (third) add_byte(8'($urandom_range(0, 255)) & 8'hFE);
		for (int f = 0; f < 14; f++) begin
			if (!mask[f] || (f >= 7 && !o0[0])) continue;
			case (f)
				0, 4, 11: push_rand(2);
				1, 3, 9: push_rand(1);
				2: push_rand(3);
				8, 10: push_rand(8);
				5, 6: begin
					prim = 8'($urandom_range(0, 255)) & 8'hFE;
					if (allow_err && $urandom_range(0, 14) == 0) begin
						add_byte(prim | 8'h01);
						add_byte(8'($urandom_range(0, 255)) & 8'hFE);
					end else begin
						add_byte(prim);
						if (prim[7]) push_rand(1);
						if (prim[4]) push_rand(1);
						if (prim[3]) push_rand(1);
						if (prim[2]) push_rand(f == 5 ? 2 : 1);
					end
				end
				7: begin
					n = $urandom_range(0, 3);
					add_byte(n[7:0]);
					push_rand(2 * n);
				end
				12: begin
					len = $urandom_range(0, 6);
					add_byte(len[7:0]);
					if (len >= 2) push_rand(len - 1);
				end
				default: begin
					sp.delete();
					sub = ($urandom_range(0, 2) != 0 ? 8'h80 : 8'h00)
						| (8'($urandom_range(0, 255)) & 8'h7E);
					sp.insert(sp.size(), sub);
					if (sub[7]) begin
						n = $urandom_range(0, 4);
						sp.insert(sp.size(), n[7:0]);
						repeat (n) sp.insert(sp.size(), 8'($urandom_range(0, 255)));
					end
					repeat ($urandom_range(0, 2)) sp.insert(sp.size(), 8'($urandom_range(0, 255)));
					len = sp.size() + 1;
					if ($urandom_range(0, 4) == 0) len = $urandom_range(0, len);
					add_byte(len[7:0]);
					for (int i = 0; i < len - 1; i++) add_byte(sp[i]);
				end
			endcase
		end
	endtask

	task automatic send_block(bit allow_err);
		int total, n, p;
		blk.delete();
		add_byte(ac034_pkg::CAT_CODE);
		add_byte(8'd0);
		add_byte(8'd0);
		repeat ($urandom_range(1, 3)) build_record(allow_err);
		total = blk.size();
		blk[1] = total[15:8];
		blk[2] = total[7:0];
		if (allow_err && $urandom_range(0, 99) < 25) begin
			case ($urandom_range(0, 6))
				0: blk[0] = ac034_pkg::CAT_CODE ^ 8'($urandom_range(1, 255));
				1: begin
					n = $urandom_range(1, total - 1);
					repeat (n) void'(blk.pop_back());
				end
				2: begin
					blk[1] = 8'd0;
					blk[2] = 8'($urandom_range(0, 2));
				end
				3: begin
					n = total - $urandom_range(1, total - 4);
					blk[1] = n[15:8];
					blk[2] = n[7:0];
				end
				4: push_rand($urandom_range(1, 3));
				5: begin
					p = $urandom_range(3, total - 1);
					blk[p] = blk[p] ^ (8'h01 << $urandom_range(0, 7));
				end
				default: begin
					blk.delete();
					push_rand($urandom_range(1, 8));
				end
			endcase
		end
		send_bytes(blk);
	endtask

	task automatic wait_idle();
		while (pending_bytes.size() > 0 || s_axis_tvalid || expected_items.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(logic v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		skip_sp = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_phase(int nbytes, bit with_hold);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < nbytes || (with_hold && hold_req == 0)) begin
			send_idle = ($urandom_range(0, 4) != 0);
			recv_idle = ($urandom_range(0, 4) != 0);
			if (with_hold && bytes_sent - start > nbytes / 2 && hold_req == 0) begin
				send_idle = 1'b0;
				hold_req = 1;
			end
			send_block($urandom_range(0, 9) != 0);
			while (pending_bytes.size() > 4) @(posedge clk);
		end
		wait_idle();
	endtask

	initial begin
		decoder_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		write_cfg(1'b0);

		// Bad category, header cut short, length below minimum, empty block,
		// largest length cut short, FX bits that run past the block end, and one short valid record.
		send_bytes('{8'h00});
		send_bytes('{ac034_pkg::CAT_CODE});
		send_bytes('{ac034_pkg::CAT_CODE, 8'h00});
		send_bytes('{ac034_pkg::CAT_CODE, 8'h00, 8'h02});
		send_bytes('{ac034_pkg::CAT_CODE, 8'h00, 8'h03});
		send_bytes('{ac034_pkg::CAT_CODE, 8'hFF, 8'hFF, 8'h00});
		send_bytes('{ac034_pkg::CAT_CODE, 8'h00, 8'h04, 8'h01});
		send_bytes('{ac034_pkg::CAT_CODE, 8'h00, 8'h05, 8'h04, 8'h81});
		send_bytes('{ac034_pkg::CAT_CODE, 8'h00, 8'h07, 8'h82, 8'h06, 8'h01, 8'h00});
		wait_idle();

		random_phase(70, 1'b1);
		write_cfg(1'b1);
		random_phase(65, 1'b0);
		write_cfg(1'b0);
		random_phase(65, 1'b0);

		repeat (20) @(posedge clk);
		$display("Sent %0d bytes in %0d blocks, checked %0d items; special field both",
			bytes_sent, blocks_sent, items_seen);
		$display("decoded and skipped, with corrupted blocks and a long output stall.");
		if (errors == 0 && expected_items.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d items still expected", errors,
				expected_items.size());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> asterix_cat034_record_parser_unit.f
rtl/ac034_pkg.sv
rtl/ac034_parse_core.sv
rtl/asterix_cat034_record_parser_unit.sv
sim/asterix_cat034_record_parser_unit_test.sv
